/* design/sha256_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash values, sequencer states and round helpers.
// ----------------------------------------------------------------------------
package sha256_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } state_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  function automatic logic [31:0] round_const(input logic [5:0] idx);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    return k[idx];
  endfunction

  function automatic logic [31:0] init_hash(input logic [2:0] idx);
    logic [31:0] h [8];
    h = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };
    return h[idx];
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

/* design/sha256_message_hasher_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 message hasher
// Hashes a word-wise byte message with one shared round unit, one round
// per cycle, adding the padding and length, then emits eight digest words.
// ----------------------------------------------------------------------------
// A non-last item that completes a 16-word block is followed by the load, 64 rounds
// of the single round unit and the fold, during which the input is stalled.
// A last item is followed by the padding words and the compression of each block,
// then the eight digest words, each held while the output is stalled.
// Synchronous reset loads the initial hash and clears fill and length.
module sha256_message_hasher_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] data_word,
  input  logic [2:0]  byte_count,
  input  logic        last_item,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  sha256_pkg::state_t state, state_next;

  logic [31:0] hash [8];
  logic [31:0] wv   [8];
  logic [31:0] win  [16];
  logic [3:0]  block_fill;
  logic [6:0]  round_index;
  logic [63:0] message_bits;
  logic        pad_final;   // padding ends after the current block
  logic [2:0]  emit_idx;
  logic        load_wv;

  // Padding is still owed after a fold when the last item is in but the
  // length did not yet go out.
  logic        last_pending;
  logic [1:0]  pad_stage; // 0 none, 1 word with 0x80 owed, 2 zeros/length

  logic        accept;
  logic        push;
  logic [31:0] push_word;
  logic [2:0]  cnt;
  logic [31:0] keep_mask;
  logic [31:0] last_word_val;
  logic [31:0] pad_word;
  logic        done_round;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state != sha256_pkg::ST_IDLE);
  assign cnt = (byte_count > 3'd4) ? 3'd4 : byte_count;

  // Masked last word with the pad byte after the data bytes.
  always_comb begin
    unique case (cnt)
      3'd0: keep_mask = 32'h0000_0000;
      3'd1: keep_mask = 32'hff00_0000;
      3'd2: keep_mask = 32'hffff_0000;
      3'd3: keep_mask = 32'hffff_ff00;
      default: keep_mask = 32'hffff_ffff;
    endcase
    last_word_val = (data_word & keep_mask) |
                    ({24'd0, sha256_pkg::PAD_BYTE} << (6'd24 - {cnt, 3'd0}));
  end

  // Padding words: zeros, then the length in slots 14 and 15 of the final block.
  always_comb begin
    if (pad_final && block_fill == 4'd14) pad_word = message_bits[63:32];
    else if (pad_final && block_fill == 4'd15) pad_word = message_bits[31:0];
    else pad_word = 32'd0;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      sha256_pkg::ST_IDLE: begin
        if (accept) begin
          if (block_fill == 4'd15) state_next = sha256_pkg::ST_ROUND;
          else if (last_item) state_next = sha256_pkg::ST_PAD;
        end
      end
      sha256_pkg::ST_PAD: begin
        if (block_fill == 4'd15) state_next = sha256_pkg::ST_ROUND;
      end
      sha256_pkg::ST_ROUND: begin
        if (done_round) state_next = sha256_pkg::ST_FOLD;
      end
      sha256_pkg::ST_FOLD: begin
        if (pad_final) state_next = sha256_pkg::ST_EMIT;
        else if (last_pending) state_next = sha256_pkg::ST_PAD;
        else state_next = sha256_pkg::ST_IDLE;
      end
      sha256_pkg::ST_EMIT: begin
        if (!out_stall && emit_idx == 3'd7) state_next = sha256_pkg::ST_IDLE;
      end
      default: state_next = sha256_pkg::ST_IDLE;
    endcase
  end

  // Word pushes and their values.
  always_comb begin
    push = 1'b0;
    push_word = data_word;
    if (state == sha256_pkg::ST_IDLE && accept) begin
      push = 1'b1;
      push_word = (last_item && cnt != 3'd4) ? last_word_val : data_word;
    end else if (state == sha256_pkg::ST_PAD) begin
      push = 1'b1;
      push_word = (pad_stage == 2'd1) ? 32'h8000_0000 : pad_word;
    end
  end

  assign last_pending = (pad_stage != 2'd0);
  assign done_round = (round_index == 7'd63);
  assign load_wv = push && (block_fill == 4'd15);

  // Round unit and schedule extension.
  logic [31:0] w_cur, w_new, s0, s1, t1, t2;
  always_comb begin
    s0 = sha256_pkg::rotr(win[1], 7) ^ sha256_pkg::rotr(win[1], 18) ^ (win[1] >> 3);
    s1 = sha256_pkg::rotr(win[14], 17) ^ sha256_pkg::rotr(win[14], 19)
         ^ (win[14] >> 10);
    w_new = win[0] + s0 + win[9] + s1;
    w_cur = (round_index < 7'd16) ? win[0] : w_new;
    t1 = wv[7] + (sha256_pkg::rotr(wv[4], 6) ^ sha256_pkg::rotr(wv[4], 11)
         ^ sha256_pkg::rotr(wv[4], 25)) + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6]))
         + sha256_pkg::round_const(round_index[5:0]) + w_cur;
    t2 = (sha256_pkg::rotr(wv[0], 2) ^ sha256_pkg::rotr(wv[0], 13)
         ^ sha256_pkg::rotr(wv[0], 22))
         + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha256_pkg::ST_IDLE;
      block_fill <= 4'd0;
      round_index <= 7'd0;
      message_bits <= 64'd0;
      pad_stage <= 2'd0;
      pad_final <= 1'b0;
      emit_idx <= 3'd0;
    end else begin
      state <= state_next;
      if (push) block_fill <= block_fill + 4'd1;
      if (state == sha256_pkg::ST_IDLE && accept) begin
        message_bits <= message_bits + (last_item ? {58'd0, cnt, 3'd0} : 64'd32);
        if (last_item) begin
          pad_stage <= (cnt == 3'd4) ? 2'd1 : 2'd2;
          pad_final <= (block_fill <= 4'd13) && (cnt != 3'd4 || block_fill <= 4'd12);
        end
      end else if (state == sha256_pkg::ST_PAD) begin
        // The length word closes the padding; otherwise zeros follow.
        if (block_fill == 4'd15 && pad_final) pad_stage <= 2'd0;
        else pad_stage <= 2'd2;
        if (pad_stage == 2'd1) pad_final <= (block_fill <= 4'd13);
        else if (block_fill < 4'd14 && pad_stage == 2'd2) pad_final <= 1'b1;
      end
      if (state == sha256_pkg::ST_ROUND) round_index <= round_index + 7'd1;
      else round_index <= 7'd0;
      if (state == sha256_pkg::ST_FOLD && pad_final) begin
        message_bits <= 64'd0;
        pad_final <= 1'b0;
      end
      if (state == sha256_pkg::ST_EMIT && !out_stall) begin
        emit_idx <= emit_idx + 3'd1;
        if (emit_idx == 3'd7) pad_stage <= 2'd0;
      end
    end
  end

  // Hash, working variables and schedule window.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) hash[i] <= sha256_pkg::init_hash(3'(i));
    end else begin
      if (state == sha256_pkg::ST_FOLD) begin
        for (int i = 0; i < 8; i++) hash[i] <= hash[i] + wv[i];
      end
      if (state == sha256_pkg::ST_EMIT && !out_stall && emit_idx == 3'd7) begin
        for (int i = 0; i < 8; i++) hash[i] <= sha256_pkg::init_hash(3'(i));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) win[block_fill] <= push_word;
    if (state == sha256_pkg::ST_ROUND) begin
      for (int i = 0; i < 15; i++) win[i] <= win[i + 1];
      win[15] <= w_cur;
      wv[7] <= wv[6];
      wv[6] <= wv[5];
      wv[5] <= wv[4];
      wv[4] <= wv[3] + t1;
      wv[3] <= wv[2];
      wv[2] <= wv[1];
      wv[1] <= wv[0];
      wv[0] <= t1 + t2;
    end else if (load_wv) begin
      for (int i = 0; i < 8; i++) wv[i] <= hash[i];
    end
  end

  // Result outputs.
  always_comb begin
    out_valid = (state == sha256_pkg::ST_EMIT);
    digest_word = hash[emit_idx];
    word_index = emit_idx;
    last_word = (emit_idx == 3'd7);
  end

endmodule

/* verif/sha256_message_hasher_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 message hasher testbench
// Drives messages as word items with random idling on both sides, predicts
// the digest words with a behavioral SHA-256 model and checks every result.
// ----------------------------------------------------------------------------
module sha256_message_hasher_top_tb;

  // One input item and one digest result.
  typedef struct {
    logic [31:0] data;
    logic [2:0]  count;
    logic        last;
  } msg_item_t;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        final_word;
  } digest_res_t;

  // Directed row: an item plus an optional typed-in digest (valid on last).
  typedef struct {
    msg_item_t   item;
    logic        has_digest;
    logic [31:0] digest0;
  } dir_row_t;

  localparam int NUM_DIR = 12;
  localparam int NUM_RAND = 340;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] data_word;
  logic [2:0]  byte_count;
  logic        last_item;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  // Predictor state.
  logic [31:0] hash_state [8];
  logic [31:0] block_words [16];
  int unsigned block_fill_cnt;
  logic [63:0] msg_bit_len;

  digest_res_t digest_queue [$];
  int          error_count;
  int          report_count;
  bit          no_idle;
  dir_row_t    dir_rows [NUM_DIR];

  sha256_message_hasher_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_word   (data_word),
    .byte_count  (byte_count),
    .last_item   (last_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("sha256_message_hasher_top test failed");
    $finish;
  end

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] sha_k(int idx);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    return k[idx];
  endfunction

  function automatic logic [31:0] sha_iv(int idx);
    logic [31:0] h [8];
    h = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };
    return h[idx];
  endfunction

  task automatic load_iv();
    for (int i = 0; i < 8; i++) hash_state[i] = sha_iv(i);
    block_fill_cnt = 0;
    msg_bit_len = '0;
  endtask

  // Run the 64 rounds on the full block and fold into the running hash.
  task automatic compress();
    logic [31:0] v [8];
    logic [31:0] w [64];
    logic [31:0] t1, t2, s0, s1;
    for (int i = 0; i < 16; i++) w[i] = block_words[i];
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_k(r) + w[r];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endtask

  task automatic add_word(logic [31:0] w);
    block_words[block_fill_cnt] = w;
    block_fill_cnt++;
    if (block_fill_cnt == 16) begin
      block_fill_cnt = 0;
      compress();
    end
  endtask

  // Predict the results of one accepted item; queue the digest on a last item.
  task automatic predict_digest(msg_item_t it, logic chk, logic [31:0] d0);
    int unsigned n;
    logic [31:0] keep;
    digest_res_t res;
    if (!it.last) begin
      msg_bit_len += 32;
      add_word(it.data);
    end else begin
      n = (it.count > 4) ? 4 : it.count;
      msg_bit_len += n * 8;
      if (n == 4) begin
        add_word(it.data);
        add_word(32'h8000_0000);
      end else begin
        keep = (n == 0) ? 32'h0 : (32'hffff_ffff << (32 - 8 * n));
        add_word((it.data & keep) | (32'(sha256_pkg::PAD_BYTE) << (24 - 8 * n)));
      end
      while (block_fill_cnt != 14) add_word(32'h0);
      add_word(msg_bit_len[63:32]);
      add_word(msg_bit_len[31:0]);
      // Typed-in first word must agree with the predictor as well.
      if (chk && hash_state[0] !== d0) begin
        error_count++;
        if (report_count < 10) begin
          report_count++;
          $display("table digest mismatch: table %h predictor %h", d0, hash_state[0]);
        end
      end
      for (int i = 0; i < 8; i++) begin
        res.word = hash_state[i];
        res.index = 3'(i);
        res.final_word = (i == 7);
        digest_queue = {digest_queue, res};
      end
      load_iv();
    end
  endtask

  task automatic send_item(msg_item_t it, logic chk, logic [31:0] d0);
    int gap;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 3);
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    data_word  <= it.data;
    byte_count <= it.count;
    last_item  <= it.last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_digest(it, chk, d0);
    @(negedge clk);
  endtask

  // Result checker.
  always @(posedge clk) begin
    digest_res_t exp_res;
    if (!rst && out_valid && !out_stall) begin
      if (digest_queue.size() == 0) begin
        error_count++;
        if (report_count < 10) begin
          report_count++;
          $display("unexpected digest word %h index %0d", digest_word, word_index);
        end
      end else begin
        exp_res = digest_queue.pop_front();
        if (digest_word !== exp_res.word || word_index !== exp_res.index ||
            last_word !== exp_res.final_word) begin
          error_count++;
          if (report_count < 10) begin
            report_count++;
            $display("digest mismatch: exp %h/%0d/%0b got %h/%0d/%0b",
                     exp_res.word, exp_res.index, exp_res.final_word,
                     digest_word, word_index, last_word);
          end
        end
      end
    end
  end

  // Output stall in random bursts, none in the final part.
  initial begin
    int burst;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!no_idle && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 3);
        out_stall <= 1'b1;
        repeat (burst) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Main stimulus.
  initial begin
    msg_item_t it;
    int msg_len;
    int sent;
    int wait_cnt;
    rst = 1'b1;
    in_valid = 1'b0;
    data_word = '0;
    byte_count = '0;
    last_item = 1'b0;
    no_idle = 1'b0;
    error_count = 0;
    report_count = 0;
    load_iv();

    // Known digests: empty message and "abc"; then extremes and ignored counts.
    dir_rows[0]  = '{'{32'hdead_beef, 3'd0, 1'b1}, 1'b1, 32'he3b0c442};
    dir_rows[1]  = '{'{32'h6162_63ff, 3'd3, 1'b1}, 1'b1, 32'hba7816bf};
    dir_rows[2]  = '{'{32'hffff_ffff, 3'd0, 1'b0}, 1'b0, 32'h0};
    dir_rows[3]  = '{'{32'h0000_0000, 3'd7, 1'b0}, 1'b0, 32'h0};
    dir_rows[4]  = '{'{32'hffff_ffff, 3'd7, 1'b1}, 1'b0, 32'h0};
    dir_rows[5]  = '{'{32'h0000_0000, 3'd4, 1'b1}, 1'b0, 32'h0};
    dir_rows[6]  = '{'{32'h1234_5678, 3'd1, 1'b1}, 1'b0, 32'h0};
    dir_rows[7]  = '{'{32'hffff_ffff, 3'd2, 1'b1}, 1'b0, 32'h0};
    dir_rows[8]  = '{'{32'haaaa_aaaa, 3'd5, 1'b0}, 1'b0, 32'h0};
    dir_rows[9]  = '{'{32'h5555_5555, 3'd6, 1'b1}, 1'b0, 32'h0};
    dir_rows[10] = '{'{32'h8000_0001, 3'd3, 1'b1}, 1'b0, 32'h0};
    dir_rows[11] = '{'{32'h0000_0000, 3'd0, 1'b1}, 1'b1, 32'he3b0c442};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i])
      send_item(dir_rows[i].item, dir_rows[i].has_digest, dir_rows[i].digest0);

    // Block boundaries: messages of 13 to 17 full words with every tail size.
    for (int len = 13; len <= 17; len++) begin
      for (int j = 0; j < len; j++) begin
        it = '{$urandom, 3'($urandom), 1'b0};
        send_item(it, 1'b0, 32'h0);
      end
      it = '{$urandom, 3'(len % 5), 1'b1};
      send_item(it, 1'b0, 32'h0);
    end

    // Random messages, mostly short, a few spanning several blocks.
    sent = 0;
    while (sent < NUM_RAND) begin
      if (sent > NUM_RAND - 60) no_idle = 1'b1;
      msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                            : $urandom_range(0, 18);
      for (int j = 0; j < msg_len; j++) begin
        it = '{$urandom, 3'($urandom), 1'b0};
        send_item(it, 1'b0, 32'h0);
      end
      it = '{$urandom, 3'($urandom), 1'b1};
      send_item(it, 1'b0, 32'h0);
      sent += msg_len + 1;
    end
    in_valid <= 1'b0;
    no_idle = 1'b1;

    wait_cnt = 0;
    while (digest_queue.size() != 0 && wait_cnt < 100000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (200) @(posedge clk);

    if (error_count == 0 && digest_queue.size() == 0) begin
      $display("sha256_message_hasher_top test passed");
    end else begin
      $display("sha256_message_hasher_top test failed");
    end
    $finish;
  end

endmodule

/* files.f */
design/sha256_pkg.sv
design/sha256_message_hasher_top.sv
verif/sha256_message_hasher_top_tb.sv
